// ===== design/gbn_pkg.sv =====
package gbn_pkg;

  // Sequence width default
  localparam int unsigned SEQ_BITS_DEF = 16;

  // Field widths fixed by the interface
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned WINDOW_W  = 7;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned TYPE_W    = 8;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Commands
  localparam logic [CMD_W-1:0] CMD_REQUEST  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  // Only this packet type counts as an acknowledgement
  localparam logic [TYPE_W-1:0] ACK_TYPE_ACK = 8'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_SENT    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_DONE    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_ACKED   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_LENGTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [FIELD_W-1:0]  PACKET_COUNT_RST = 16'd0;
  localparam logic [FIELD_W-1:0]  PAYLOAD_SIZE_RST = 16'd12000;
  localparam logic [FIELD_W-1:0]  LAST_LENGTH_RST  = 16'd0;
  localparam logic [WINDOW_W-1:0] WINDOW_SIZE_RST  = 7'd8;

  // Right edge after reset: smaller of window size and packet count
  localparam logic [FIELD_W-1:0] RIGHT_EDGE_RST =
    ({9'd0, WINDOW_SIZE_RST} < PACKET_COUNT_RST) ? {9'd0, WINDOW_SIZE_RST}
                                                 : PACKET_COUNT_RST;

  typedef struct packed {
    logic [FIELD_W-1:0]  packet_count;
    logic [FIELD_W-1:0]  payload_size;
    logic [FIELD_W-1:0]  last_length;
    logic [WINDOW_W-1:0] window_size;
  } cfg_t;

  // Next configuration and whether the right edge must be placed again
  typedef struct packed {
    logic recalc;
    cfg_t next;
  } cfg_upd_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [TYPE_W-1:0]  ack_type;
    logic [FIELD_W-1:0] ack_number;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  seq_number;
    logic [FIELD_W-1:0]  packet_length;
    logic                final_packet;
    logic [FIELD_W-1:0]  left_edge;
    logic [FIELD_W-1:0]  right_edge;
  } result_t;

endpackage

// ===== design/gbn_cfg_regs.sv =====
module gbn_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gbn_pkg::FIELD_W-1:0]    cfg_data_i,
  output gbn_pkg::cfg_t                  cfg_o,
  output gbn_pkg::cfg_upd_t              cfg_upd_o
);
  import gbn_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic recalc;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  // Decode one register write
  always_comb begin
    cfg_d  = cfg_q;
    recalc = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PACKET_COUNT: begin
          cfg_d.packet_count = cfg_data_i;
          recalc             = 1'b1;
        end
        REG_PAYLOAD_SIZE: cfg_d.payload_size = cfg_data_i;
        REG_LAST_LENGTH:  cfg_d.last_length  = cfg_data_i;
        REG_WINDOW_SIZE: begin
          cfg_d.window_size = cfg_data_i[WINDOW_W-1:0];
          recalc            = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.packet_count <= PACKET_COUNT_RST;
      cfg_q.payload_size <= PAYLOAD_SIZE_RST;
      cfg_q.last_length  <= LAST_LENGTH_RST;
      cfg_q.window_size  <= WINDOW_SIZE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o            = cfg_q;
  assign cfg_upd_o.recalc = recalc;
  assign cfg_upd_o.next   = cfg_d;

endmodule

// ===== design/gbn_window_ctrl.sv =====
module gbn_window_ctrl #(
  parameter int unsigned SEQ_BITS = gbn_pkg::SEQ_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbn_pkg::cfg_t     cfg_i,
  input  gbn_pkg::cfg_upd_t cfg_upd_i,
  input  logic              step_i,
  input  gbn_pkg::item_t    item_i,
  output gbn_pkg::result_t  result_o
);
  import gbn_pkg::*;

  logic [SEQ_BITS-1:0] left_q, left_d;
  logic [SEQ_BITS-1:0] right_q, right_d;
  logic [SEQ_BITS-1:0] sp_q, sp_d;

  logic [SEQ_BITS-1:0] pc;
  logic [SEQ_BITS-1:0] ack_num;
  logic [SEQ_BITS-1:0] ack_left;
  logic [SEQ_BITS-1:0] ack_right;
  logic [SEQ_BITS-1:0] cfg_right;
  logic [SEQ_BITS:0]   seq_w;

  // Right edge: left edge plus span, clamped to the packet count
  function automatic logic [SEQ_BITS-1:0] place_right(
    input logic [SEQ_BITS-1:0] left,
    input logic [WINDOW_W-1:0] wsize,
    input logic [SEQ_BITS-1:0] count
  );
    logic [WINDOW_W-1:0] span;
    logic [SEQ_BITS:0]   sum;
    span = (wsize == '0) ? WINDOW_W'(1) : wsize;
    sum  = {1'b0, left} + (SEQ_BITS+1)'(span);
    return (sum > {1'b0, count}) ? count : sum[SEQ_BITS-1:0];
  endfunction

  assign pc      = SEQ_BITS'(cfg_i.packet_count);
  assign ack_num = SEQ_BITS'(item_i.ack_number);
  assign seq_w   = {1'b0, sp_q} + (SEQ_BITS+1)'(1);

  // Window after an accepted ack, and after a configuration write
  assign ack_left  = (ack_num > pc) ? pc : ack_num;
  assign ack_right = place_right(ack_left, cfg_i.window_size, pc);
  assign cfg_right = place_right(left_q, cfg_upd_i.next.window_size,
                                 SEQ_BITS'(cfg_upd_i.next.packet_count));

  // Work out one command
  always_comb begin
    left_d                 = left_q;
    right_d                = right_q;
    sp_d                   = sp_q;
    result_o.status        = STATUS_IGNORED;
    result_o.seq_number    = '0;
    result_o.packet_length = '0;
    result_o.final_packet  = 1'b0;
    unique case (item_i.command)
      CMD_REQUEST: begin
        if (left_q >= pc) begin
          result_o.status = STATUS_DONE;
        end else if (sp_q >= right_q) begin
          result_o.status = STATUS_FULL;
        end else begin
          result_o.status     = STATUS_SENT;
          result_o.seq_number = FIELD_W'(seq_w);
          if (seq_w == {1'b0, pc}) begin
            result_o.final_packet  = 1'b1;
            result_o.packet_length = cfg_i.last_length;
          end else begin
            result_o.packet_length = cfg_i.payload_size;
          end
          sp_d = seq_w[SEQ_BITS-1:0];
        end
      end
      CMD_ACK: begin
        if (item_i.ack_type == ACK_TYPE_ACK && ack_num > left_q) begin
          left_d          = ack_left;
          right_d         = ack_right;
          sp_d            = (sp_q < ack_left) ? ack_left : sp_q;
          result_o.status = STATUS_ACKED;
        end
      end
      CMD_TIMEOUT: sp_d = left_q;
      CMD_RESERVED: ;
    endcase
    result_o.left_edge  = FIELD_W'(left_d);
    result_o.right_edge = FIELD_W'(right_d);
  end

  // Place the right edge on a packet count or window size write, else update the window on a processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= SEQ_BITS'(RIGHT_EDGE_RST);
      sp_q    <= '0;
    end else if (cfg_upd_i.recalc) begin
      right_q <= cfg_right;
    end else if (step_i) begin
      left_q  <= left_d;
      right_q <= right_d;
      sp_q    <= sp_d;
    end
  end

  // Right edge never passes the packet count
  a_right_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    right_q <= pc)
    else $error("right edge beyond packet count");

  // A sent packet advances the send pointer by one
  a_send_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !cfg_upd_i.recalc && result_o.status == STATUS_SENT
    |=> sp_q == $past(sp_q) + 1'b1)
    else $error("send pointer did not advance");

  // A timeout rewinds the send pointer to the left edge
  a_timeout_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !cfg_upd_i.recalc && item_i.command == CMD_TIMEOUT
    |=> sp_q == $past(left_q))
    else $error("timeout did not rewind");

  // After an applied ack the send pointer is not behind the left edge
  a_ack_pointer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !cfg_upd_i.recalc && result_o.status == STATUS_ACKED
    |=> sp_q >= left_q)
    else $error("send pointer behind left edge after ack");

endmodule

// ===== design/go_back_n_send_window_core.sv =====
// Go-back-N sender window control. Each item is one command: request the
// next packet, apply a received ack, or rewind on a retransmit timeout.
// Every item gives exactly one result with the status, the packet to send
// (sequence number, length, final flag) and the window edges after the
// command. One item is taken every clock cycle while results are taken.
// An item is held in the input register until the result register is
// empty or being taken; the result register then takes its result. The
// window registers are updated at that same edge, so the next item sees
// them at once. A stalled result holds the input register, and a new
// item is refused while both are full. The user must write the
// configuration registers through their own port only while no item is
// in flight; the block itself does not enforce it. Writing the packet
// count or window size places the right edge again.
module go_back_n_send_window_core #(
  parameter int unsigned SEQ_BITS = gbn_pkg::SEQ_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gbn_pkg::FIELD_W-1:0]   cfg_data_i,
  // command items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [gbn_pkg::CMD_W-1:0]     command_i,
  input  logic [gbn_pkg::TYPE_W-1:0]    ack_type_i,
  input  logic [gbn_pkg::FIELD_W-1:0]   ack_number_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gbn_pkg::STATUS_W-1:0]  status_o,
  output logic [gbn_pkg::FIELD_W-1:0]   seq_number_o,
  output logic [gbn_pkg::FIELD_W-1:0]   packet_length_o,
  output logic                          final_packet_o,
  output logic [gbn_pkg::FIELD_W-1:0]   left_edge_o,
  output logic [gbn_pkg::FIELD_W-1:0]   right_edge_o
);
  import gbn_pkg::*;

  cfg_t     cfg;
  cfg_upd_t cfg_upd;
  item_t    item_q;
  result_t  result, result_q;
  logic     in_vld_q, in_vld_d;
  logic     out_vld_q, out_vld_d;
  logic     out_free;
  logic     step;
  logic     accept;

  gbn_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .cfg_upd_o   (cfg_upd)
  );

  gbn_window_ctrl #(
    .SEQ_BITS (SEQ_BITS)
  ) u_window_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .cfg_upd_i (cfg_upd),
    .step_i    (step),
    .item_i    (item_q),
    .result_o  (result)
  );

  // Advance when the result register is empty or being taken
  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_vld_d  = accept || (in_vld_q && !step);
  assign out_vld_d = step || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture the incoming item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.command    <= command_i;
      item_q.ack_type   <= ack_type_i;
      item_q.ack_number <= ack_number_i;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = result_q.status;
  assign seq_number_o    = result_q.seq_number;
  assign packet_length_o = result_q.packet_length;
  assign final_packet_o  = result_q.final_packet;
  assign left_edge_o     = result_q.left_edge;
  assign right_edge_o    = result_q.right_edge;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import gbn_pkg::*;

  localparam int QUIET_LIMIT       = 2000;
  localparam int TRAFFIC_PER_PHASE = 180;

  // One line of the opening script: a register write or a command item
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [FIELD_W-1:0]   reg_data;
    item_t                cmd;
    bit                   typed;
    result_t              want;
  } window_row_t;

  logic clk;
  logic rst_ni = 1'b0;

  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [FIELD_W-1:0]   cfg_data_i   = '0;

  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     command_i    = '0;
  logic [TYPE_W-1:0]    ack_type_i   = '0;
  logic [FIELD_W-1:0]   ack_number_i = '0;

  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [FIELD_W-1:0]   seq_number_o;
  logic [FIELD_W-1:0]   packet_length_o;
  logic                 final_packet_o;
  logic [FIELD_W-1:0]   left_edge_o;
  logic [FIELD_W-1:0]   right_edge_o;

  // Shadow of the sender window and its registers
  logic [FIELD_W-1:0]  cfg_count    = PACKET_COUNT_RST;
  logic [FIELD_W-1:0]  cfg_payload  = PAYLOAD_SIZE_RST;
  logic [FIELD_W-1:0]  cfg_last     = LAST_LENGTH_RST;
  logic [WINDOW_W-1:0] cfg_window   = WINDOW_SIZE_RST;
  logic [FIELD_W-1:0]  shadow_left  = '0;
  logic [FIELD_W-1:0]  shadow_right = RIGHT_EDGE_RST;
  logic [FIELD_W-1:0]  send_ptr     = '0;

  result_t window_results_q[$];

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int results_seen   = 0;
  int items_sent     = 0;
  int traffic_items  = 0;
  int reg_writes     = 0;
  int transfers      = 0;
  int status_seen[5] = '{default: 0};

  go_back_n_send_window_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .ack_type_i      (ack_type_i),
    .ack_number_i    (ack_number_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .seq_number_o    (seq_number_o),
    .packet_length_o (packet_length_o),
    .final_packet_o  (final_packet_o),
    .left_edge_o     (left_edge_o),
    .right_edge_o    (right_edge_o)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Place the right edge: left plus window (zero counts as one), capped at the count
  function automatic void place_right_edge();
    logic [FIELD_W:0] reach;
    reach = {1'b0, shadow_left} + ((cfg_window == '0) ? 17'd1 : {10'd0, cfg_window});
    shadow_right = (reach > {1'b0, cfg_count}) ? cfg_count : reach[FIELD_W-1:0];
  endfunction

  function automatic void window_write_reg(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [FIELD_W-1:0] data);
    case (idx)
      REG_PACKET_COUNT: begin
        cfg_count = data;
        place_right_edge();
      end
      REG_PAYLOAD_SIZE: cfg_payload = data;
      REG_LAST_LENGTH:  cfg_last = data;
      REG_WINDOW_SIZE: begin
        cfg_window = data[WINDOW_W-1:0];
        place_right_edge();
      end
      default: ;
    endcase
  endfunction

  // Advance the shadow window by one command and return the result it gives
  function automatic result_t window_step(input item_t it);
    result_t          r;
    logic [FIELD_W:0] next_seq;
    r = '0;
    r.status = STATUS_IGNORED;
    case (it.command)
      CMD_REQUEST: begin
        if (shadow_left >= cfg_count) begin
          r.status = STATUS_DONE;
        end else if (send_ptr >= shadow_right) begin
          r.status = STATUS_FULL;
        end else begin
          next_seq       = {1'b0, send_ptr} + 17'd1;
          r.status       = STATUS_SENT;
          r.seq_number   = next_seq[FIELD_W-1:0];
          r.final_packet = (next_seq == {1'b0, cfg_count});
          r.packet_length = r.final_packet ? cfg_last : cfg_payload;
          send_ptr       = next_seq[FIELD_W-1:0];
        end
      end
      CMD_ACK: begin
        if (it.ack_type == ACK_TYPE_ACK && it.ack_number > shadow_left) begin
          shadow_left = (it.ack_number > cfg_count) ? cfg_count : it.ack_number;
          place_right_edge();
          if (send_ptr < shadow_left) send_ptr = shadow_left;
          r.status = STATUS_ACKED;
        end
      end
      CMD_TIMEOUT: send_ptr = shadow_left;
      default: ;
    endcase
    r.left_edge  = shadow_left;
    r.right_edge = shadow_right;
    return r;
  endfunction

  function automatic item_t make_item(input logic [CMD_W-1:0] cmd,
                                      input logic [TYPE_W-1:0] kind,
                                      input logic [FIELD_W-1:0] num);
    item_t it;
    it.command    = cmd;
    it.ack_type   = kind;
    it.ack_number = num;
    return it;
  endfunction

  function automatic window_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [FIELD_W-1:0] data);
    window_row_t row;
    row = '{default: '0};
    row.is_cfg   = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic window_row_t cmd_row(input item_t it);
    window_row_t row;
    row = '{default: '0};
    row.cmd = it;
    return row;
  endfunction

  function automatic window_row_t checked_row(input item_t it,
                                              input logic [STATUS_W-1:0] st,
                                              input logic [FIELD_W-1:0] seq,
                                              input logic [FIELD_W-1:0] len,
                                              input logic fin,
                                              input logic [FIELD_W-1:0] left,
                                              input logic [FIELD_W-1:0] right);
    window_row_t row;
    row = cmd_row(it);
    row.typed              = 1'b1;
    row.want.status        = st;
    row.want.seq_number    = seq;
    row.want.packet_length = len;
    row.want.final_packet  = fin;
    row.want.left_edge     = left;
    row.want.right_edge    = right;
    return row;
  endfunction

  // Mostly requests and plausible acks; the rest timeouts and junk
  function automatic item_t next_command(output bit noise);
    int    roll;
    int    lo;
    int    hi;
    item_t it;
    roll  = $urandom_range(0, 99);
    noise = 1'b0;
    it = make_item(CMD_REQUEST, TYPE_W'($urandom_range(0, 255)),
                   FIELD_W'($urandom_range(0, 65535)));
    if (roll >= 55 && roll < 82) begin
      lo = shadow_left;
      hi = send_ptr + 1;
      it.command    = CMD_ACK;
      it.ack_type   = ACK_TYPE_ACK;
      it.ack_number = FIELD_W'($urandom_range(hi, lo));
    end else if (roll >= 82 && roll < 90) begin
      it.command = CMD_TIMEOUT;
    end else if (roll >= 90) begin
      noise = 1'b1;
      if (roll < 95) begin
        it.command = CMD_ACK;
      end else if (roll < 98) begin
        it.command = CMD_RESERVED;
      end else begin
        it.command  = CMD_ACK;
        it.ack_type = ACK_TYPE_ACK;
      end
    end
    return it;
  endfunction

  // Hold off new items until every outstanding result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (window_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    window_write_reg(idx, data);
    reg_writes++;
  endtask

  // Offer one item after a random gap; predict its result once it is taken
  task automatic send_cmd(input item_t it, input bit typed, input result_t typed_res);
    result_t predicted;
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i   <= 1'b1;
    command_i    <= it.command;
    ack_type_i   <= it.ack_type;
    ack_number_i <= it.ack_number;
    do @(posedge clk); while (!(in_valid_i && !in_stall_o));
    predicted = window_step(it);
    window_results_q.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // Rewind the window to zero, set up a fresh transfer and run traffic on it
  task automatic run_transfer();
    logic [FIELD_W-1:0] pc;
    logic [FIELD_W-1:0] ps;
    logic [FIELD_W-1:0] ll;
    logic [FIELD_W-1:0] ws;
    int                 roll;
    int                 budget;
    int                 done_seen;
    item_t              it;
    bit                 noise;
    if (shadow_left != '0 || send_ptr != '0) begin
      write_reg(REG_PACKET_COUNT, '0);
      send_cmd(make_item(CMD_ACK, ACK_TYPE_ACK, 16'hFFFF), 1'b0, '0);
      send_cmd(make_item(CMD_TIMEOUT, TYPE_W'($urandom_range(0, 255)),
                         FIELD_W'($urandom_range(0, 65535))),
               1'b0, '0);
      traffic_items += 2;
    end
    roll = $urandom_range(0, 99);
    pc = (roll < 5) ? 16'd0 : (roll < 10) ? 16'hFFFF : FIELD_W'($urandom_range(1, 40));
    roll = $urandom_range(0, 99);
    ps = (roll < 10) ? 16'd1 : (roll < 20) ? 16'hFFFF : FIELD_W'($urandom_range(1, 65535));
    roll = $urandom_range(0, 99);
    ll = (roll < 10) ? 16'd0 : (roll < 20) ? 16'hFFFF : FIELD_W'($urandom_range(0, 65535));
    roll = $urandom_range(0, 99);
    if (roll < 10)      ws = 16'd0;
    else if (roll < 20) ws = 16'd127;
    else if (roll < 25) ws = FIELD_W'($urandom_range(0, 65535));
    else                ws = FIELD_W'($urandom_range(1, 16));
    write_reg(REG_PACKET_COUNT, pc);
    write_reg(REG_PAYLOAD_SIZE, ps);
    write_reg(REG_LAST_LENGTH, ll);
    write_reg(REG_WINDOW_SIZE, ws);
    transfers++;
    budget    = $urandom_range(20, 80);
    done_seen = 0;
    for (int n = 0; n < budget && done_seen < 2; n++) begin
      it = next_command(noise);
      if (it.command == CMD_REQUEST && shadow_left >= cfg_count) done_seen++;
      send_cmd(it, 1'b0, '0);
      if (!noise) traffic_items++;
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want_v,
                             input logic [FIELD_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Stall the result side at random
  always @(posedge clk) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Compare each result taken against the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (status_o < 5) status_seen[status_o]++;
      if (window_results_q.size() == 0) begin
        $display("%0t ns: result with none expected, status %0d seq %0d left %0d right %0d",
                 $time, status_o, seq_number_o, left_edge_o, right_edge_o);
        mismatches++;
      end else begin
        want = window_results_q.pop_front();
        check_field("status", FIELD_W'(want.status), FIELD_W'(status_o));
        check_field("seq_number", want.seq_number, seq_number_o);
        check_field("packet_length", want.packet_length, packet_length_o);
        check_field("final_packet", FIELD_W'(want.final_packet), FIELD_W'(final_packet_o));
        check_field("left_edge", want.left_edge, left_edge_o);
        check_field("right_edge", want.right_edge, right_edge_o);
      end
    end
  end

  // End the run if no handshake completes for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    window_row_t opening_rows[$];
    int          gap_plan[4]   = '{0, 72, 0, 34};
    int          stall_plan[4] = '{0, 0, 72, 34};

    // Straight out of reset: no packets, so a request is done; command 3 does nothing
    opening_rows.push_back(checked_row(make_item(CMD_REQUEST, 8'hFF, 16'hFFFF),
                                       STATUS_DONE, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0));
    opening_rows.push_back(checked_row(make_item(CMD_RESERVED, 8'h01, 16'h0001),
                                       STATUS_IGNORED, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0));
    // Three packets, widest lengths, zero window acting as one
    opening_rows.push_back(cfg_row(REG_PACKET_COUNT, 16'd3));
    opening_rows.push_back(cfg_row(REG_PAYLOAD_SIZE, 16'hFFFF));
    opening_rows.push_back(cfg_row(REG_LAST_LENGTH, 16'hFFFF));
    opening_rows.push_back(cfg_row(REG_WINDOW_SIZE, 16'd0));
    opening_rows.push_back(checked_row(make_item(CMD_REQUEST, 8'h00, 16'h0000),
                                       STATUS_SENT, 16'd1, 16'hFFFF, 1'b0, 16'd0, 16'd1));
    opening_rows.push_back(checked_row(make_item(CMD_REQUEST, 8'h00, 16'h0000),
                                       STATUS_FULL, 16'd0, 16'd0, 1'b0, 16'd0, 16'd1));
    // Wrong packet type, then an ack that does not pass the left edge
    opening_rows.push_back(checked_row(make_item(CMD_ACK, 8'd2, 16'd1),
                                       STATUS_IGNORED, 16'd0, 16'd0, 1'b0, 16'd0, 16'd1));
    opening_rows.push_back(checked_row(make_item(CMD_ACK, ACK_TYPE_ACK, 16'd0),
                                       STATUS_IGNORED, 16'd0, 16'd0, 1'b0, 16'd0, 16'd1));
    opening_rows.push_back(cmd_row(make_item(CMD_ACK, ACK_TYPE_ACK, 16'd1)));
    opening_rows.push_back(cmd_row(make_item(CMD_REQUEST, 8'hFF, 16'hFFFF)));
    // Go back on timeout and resend the same packet
    opening_rows.push_back(cmd_row(make_item(CMD_TIMEOUT, 8'hFF, 16'hFFFF)));
    opening_rows.push_back(cmd_row(make_item(CMD_REQUEST, 8'h00, 16'h0000)));
    // Ack far past the count saturates the left edge and drags the pointer along
    opening_rows.push_back(checked_row(make_item(CMD_ACK, ACK_TYPE_ACK, 16'hFFFF),
                                       STATUS_ACKED, 16'd0, 16'd0, 1'b0, 16'd3, 16'd3));
    opening_rows.push_back(checked_row(make_item(CMD_REQUEST, 8'h00, 16'h0000),
                                       STATUS_DONE, 16'd0, 16'd0, 1'b0, 16'd3, 16'd3));
    // Widest window and largest count: run to the top of the sequence space
    opening_rows.push_back(cfg_row(REG_WINDOW_SIZE, 16'd127));
    opening_rows.push_back(cfg_row(REG_PACKET_COUNT, 16'hFFFF));
    opening_rows.push_back(cmd_row(make_item(CMD_REQUEST, 8'h00, 16'h0000)));
    opening_rows.push_back(checked_row(make_item(CMD_ACK, ACK_TYPE_ACK, 16'hFFFE),
                                       STATUS_ACKED, 16'd0, 16'd0, 1'b0, 16'hFFFE, 16'hFFFF));
    opening_rows.push_back(cfg_row(REG_PAYLOAD_SIZE, 16'd1));
    opening_rows.push_back(cfg_row(REG_LAST_LENGTH, 16'd0));
    opening_rows.push_back(checked_row(make_item(CMD_REQUEST, 8'h00, 16'h0000),
                                       STATUS_SENT, 16'hFFFF, 16'd0, 1'b1, 16'hFFFE, 16'hFFFF));
    opening_rows.push_back(checked_row(make_item(CMD_REQUEST, 8'h00, 16'h0000),
                                       STATUS_FULL, 16'd0, 16'd0, 1'b0, 16'hFFFE, 16'hFFFF));
    opening_rows.push_back(cmd_row(make_item(CMD_TIMEOUT, 8'h00, 16'h0000)));
    opening_rows.push_back(cmd_row(make_item(CMD_REQUEST, 8'h00, 16'h0000)));
    // Window write with junk in the upper bits, then shrink the count below the left edge
    opening_rows.push_back(cfg_row(REG_WINDOW_SIZE, 16'hFF88));
    opening_rows.push_back(cfg_row(REG_PACKET_COUNT, 16'd0));
    opening_rows.push_back(checked_row(make_item(CMD_REQUEST, 8'h00, 16'h0000),
                                       STATUS_DONE, 16'd0, 16'd0, 1'b0, 16'hFFFE, 16'd0));
    opening_rows.push_back(checked_row(make_item(CMD_ACK, ACK_TYPE_ACK, 16'hFFFF),
                                       STATUS_ACKED, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0));
    opening_rows.push_back(cmd_row(make_item(CMD_TIMEOUT, 8'h00, 16'h0000)));

    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;

    foreach (opening_rows[i]) begin
      if (opening_rows[i].is_cfg) begin
        write_reg(opening_rows[i].reg_idx, opening_rows[i].reg_data);
      end else begin
        send_cmd(opening_rows[i].cmd, opening_rows[i].typed, opening_rows[i].want);
      end
    end

    // Random transfers under each mix of sender gaps and receiver stalls
    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct   = gap_plan[ph];
      recv_stall_pct = stall_plan[ph];
      while (traffic_items < (ph + 1) * TRAFFIC_PER_PHASE) run_transfer();
    end

    drain_results();
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    mismatches += window_results_q.size();

    $display("Ran %0d commands (%0d random transfers) and %0d register writes;",
             items_sent, transfers, reg_writes);
    $display("%0d results checked. Statuses seen: sent %0d, full %0d, done %0d, %s %0d, %s %0d.",
             results_seen, status_seen[0], status_seen[1], status_seen[2],
             "acked", status_seen[3], "ignored", status_seen[4]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/gbn_pkg.sv
design/gbn_cfg_regs.sv
design/gbn_window_ctrl.sv
design/go_back_n_send_window_core.sv
test/testbench.sv
